### rtl/dfr_pkg.sv
package dfr_pkg;

	// item and result payloads
	typedef struct packed {
		logic        kind;
		logic [15:0] pulse_width;
	} item_t;

	typedef struct packed {
		logic               running;
		logic               slow_spin;
		logic signed [31:0] speed_target;
		logic               spin_direction;
		logic               telemetry_request;
		logic               frame_good;
		logic               save_request;
	} result_t;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIDIR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIL_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd7;

	localparam logic [31:0] SIL_LIMIT_RST = 32'd1000;

	// configuration as seen by the datapath; span is |speed_max - speed_min|
	typedef struct packed {
		logic [15:0] zero_min;
		logic [15:0] zero_max;
		logic [15:0] one_min;
		logic [15:0] one_max;
		logic        bidir;
		logic [31:0] silence_limit;
		logic [31:0] speed_min;
		logic [31:0] span_abs;
		logic        span_neg;
	} cfg_t;

	// frame layout
	localparam int unsigned BUFFER_SIZE_DEF = 32;
	localparam int unsigned FRAME_BITS      = 16;
	localparam int unsigned THR_W           = 11;

	typedef enum logic [1:0] {
		CODE_ZERO = 2'd0,
		CODE_ONE  = 2'd1,
		CODE_ERR  = 2'd2
	} bit_code_t;

	// throttle and command codes
	localparam logic [THR_W-1:0] THR_STOP     = 11'd0;
	localparam logic [THR_W-1:0] THR_MAP_BASE = 11'd47;
	localparam logic [THR_W-1:0] THR_CMD_LIM  = 11'd37;

	localparam logic [THR_W-1:0] CMD_DIR_NORMAL    = 11'd7;
	localparam logic [THR_W-1:0] CMD_DIR_REVERSE   = 11'd8;
	localparam logic [THR_W-1:0] CMD_SAVE          = 11'd12;
	localparam logic [THR_W-1:0] CMD_SLOW_SPIN     = 11'd15;
	localparam logic [THR_W-1:0] CMD_DIR_NORMAL_T  = 11'd20;
	localparam logic [THR_W-1:0] CMD_DIR_REVERSE_T = 11'd21;

	localparam logic [15:0] REPEAT_MAX = 16'd60000;
	localparam logic [15:0] REPEAT_ARM = 16'd6;

	// speed action decided at decode, applied at the output stage
	typedef enum logic [1:0] {
		ACT_KEEP = 2'd0,
		ACT_ZERO = 2'd1,
		ACT_MAP  = 2'd2
	} speed_act_t;

	typedef struct packed {
		speed_act_t       act;
		logic [THR_W-1:0] thr_ofs;
		logic             running;
		logic             slow_spin;
		logic             spin_direction;
		logic             telemetry_request;
		logic             frame_good;
		logic             save_request;
	} dec_t;

	// scaling: x/2000 = (x>>4)/125, the /125 by reciprocal plus one correction
	localparam int unsigned PROD_W      = 43;
	localparam int unsigned DIV_SHIFT   = 4;
	localparam int unsigned B_W         = PROD_W - DIV_SHIFT;
	localparam int unsigned SPLIT       = 20;
	localparam int unsigned RECIP_W     = 34;
	localparam int unsigned RECIP_SHIFT = 40;
	localparam int unsigned QE_W        = 33;
	localparam logic [RECIP_W-1:0] RECIP   = 34'd8796093022;
	localparam logic [7:0]         DIV_ODD = 8'd125;

endpackage

### rtl/dfr_config.sv
module dfr_config (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dfr_pkg::cfg_t                    cfg
);
	import dfr_pkg::*;

	logic [15:0] zero_min_q, zero_max_q, one_min_q, one_max_q;
	logic        bidir_q;
	logic [31:0] sil_limit_q, speed_min_q, speed_max_q;
	logic [31:0] span_abs_q;
	logic        span_neg_q;
	logic [32:0] diff;

	assign diff = {speed_max_q[31], speed_max_q} - {speed_min_q[31], speed_min_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_min_q  <= '0;
			zero_max_q  <= '0;
			one_min_q   <= '0;
			one_max_q   <= '0;
			bidir_q     <= 1'b0;
			sil_limit_q <= SIL_LIMIT_RST;
			speed_min_q <= '0;
			speed_max_q <= '0;
			span_abs_q  <= '0;
			span_neg_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ZERO_MIN:  zero_min_q  <= cfg_data[15:0];
					REG_ZERO_MAX:  zero_max_q  <= cfg_data[15:0];
					REG_ONE_MIN:   one_min_q   <= cfg_data[15:0];
					REG_ONE_MAX:   one_max_q   <= cfg_data[15:0];
					REG_BIDIR:     bidir_q     <= cfg_data[0];
					REG_SIL_LIMIT: sil_limit_q <= cfg_data;
					REG_SPEED_MIN: speed_min_q <= cfg_data;
					REG_SPEED_MAX: speed_max_q <= cfg_data;
				endcase
			end
			// span magnitude fits 32 bits; registered from the limits, so it follows them in the next cycle
			span_neg_q <= diff[32];
			span_abs_q <= diff[32] ? 32'(-diff) : diff[31:0];
		end
	end

	always_comb begin
		cfg.zero_min      = zero_min_q;
		cfg.zero_max      = zero_max_q;
		cfg.one_min       = one_min_q;
		cfg.one_max       = one_max_q;
		cfg.bidir         = bidir_q;
		cfg.silence_limit = sil_limit_q;
		cfg.speed_min     = speed_min_q;
		cfg.span_abs      = span_abs_q;
		cfg.span_neg      = span_neg_q;
	end

endmodule

### rtl/dfr_decode.sv
module dfr_decode #(
	parameter int unsigned BUFFER_SIZE = dfr_pkg::BUFFER_SIZE_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dfr_pkg::item_t  item,
	input  logic            accept,
	input  logic            load,
	input  dfr_pkg::cfg_t   cfg,
	output logic            dec_valid,
	output dfr_pkg::dec_t   dec
);
	import dfr_pkg::*;

	localparam int unsigned CNT_W = $clog2(BUFFER_SIZE + 1);

	bit_code_t        hist_q [FRAME_BITS];
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      sil_q;
	logic [THR_W-1:0] last_q;
	logic [15:0]      rep_q;
	logic             dir_q, tele_q, run_q, slow_q;
	logic             s1_v_q;
	dec_t             s1_q;

	bit_code_t        code;
	logic             is_tick, is_sample, take_sample;
	logic [CNT_W-1:0] cnt_n;
	logic [31:0]      sil_n;
	logic [THR_W-1:0] last_n, thr;
	logic [15:0]      rep_n;
	logic             dir_n, tele_n, run_n, slow_n;
	logic [15:0]      word;
	logic             no_err, good;
	logic [3:0]       crc, chk;
	logic [11:0]      data;
	dec_t             rec;

	assign is_tick     = accept && (item.kind == KIND_TICK);
	assign is_sample   = accept && (item.kind == KIND_SAMPLE);
	assign take_sample = is_sample && (cnt_q < CNT_W'(BUFFER_SIZE));

	// zero window wins where the windows overlap
	always_comb begin
		priority if (item.pulse_width >= cfg.zero_min && item.pulse_width <= cfg.zero_max)
			code = CODE_ZERO;
		else if (item.pulse_width >= cfg.one_min && item.pulse_width <= cfg.one_max)
			code = CODE_ONE;
		else
			code = CODE_ERR;
	end

	// frame assembly, oldest sample is the MSB
	always_comb begin
		no_err = 1'b1;
		for (int i = 0; i < FRAME_BITS; i++) begin
			word[FRAME_BITS-1-i] = hist_q[i][0];
			if (hist_q[i] == CODE_ERR)
				no_err = 1'b0;
		end
		data = word[15:4];
		crc  = word[3:0] ^ {4{cfg.bidir}};
		chk  = data[3:0] ^ data[7:4] ^ data[11:8];
		thr  = data[11:1];
	end

	always_comb begin
		cnt_n  = cnt_q;
		sil_n  = sil_q;
		last_n = last_q;
		rep_n  = rep_q;
		dir_n  = dir_q;
		tele_n = tele_q;
		run_n  = run_q;
		slow_n = slow_q;
		good   = 1'b0;
		rec    = '0;
		rec.act = ACT_KEEP;

		if (take_sample)
			cnt_n = cnt_q + CNT_W'(1);

		if (is_tick) begin
			// silence watchdog
			if (sil_q != '1)
				sil_n = sil_q + 32'd1;
			if (sil_n > cfg.silence_limit) begin
				sil_n   = cfg.silence_limit;
				run_n   = 1'b0;
				slow_n  = 1'b0;
				rec.act = ACT_ZERO;
			end

			if (cnt_q >= CNT_W'(FRAME_BITS)) begin
				cnt_n = '0;
				good  = no_err && (crc == chk);
			end

			if (good) begin
				sil_n  = '0;
				tele_n = data[0];
				if (thr > THR_MAP_BASE) begin
					run_n       = 1'b1;
					slow_n      = 1'b0;
					rec.act     = ACT_MAP;
					rec.thr_ofs = thr - THR_MAP_BASE;
				end
				if (thr == last_q) begin
					if (rep_q < REPEAT_MAX)
						rep_n = rep_q + 16'd1;
				end else begin
					rep_n = '0;
				end
				last_n = thr;
				// special commands only while stopped and repeated
				if (thr < THR_CMD_LIM && !run_n && rep_n > REPEAT_ARM) begin
					unique case (thr)
						CMD_DIR_NORMAL: begin
							dir_n = 1'b0;
							rec.save_request = 1'b1;
						end
						CMD_DIR_REVERSE: begin
							dir_n = 1'b1;
							rec.save_request = 1'b1;
						end
						CMD_SAVE:          rec.save_request = 1'b1;
						CMD_SLOW_SPIN: begin
							run_n   = 1'b0;
							slow_n  = 1'b1;
							rec.act = ACT_ZERO;
						end
						CMD_DIR_NORMAL_T:  dir_n = 1'b0;
						CMD_DIR_REVERSE_T: dir_n = 1'b1;
						default: ;
					endcase
				end
				if (thr == THR_STOP) begin
					run_n   = 1'b0;
					slow_n  = 1'b0;
					rec.act = ACT_ZERO;
				end
			end
		end

		rec.running           = run_n;
		rec.slow_spin         = slow_n;
		rec.spin_direction    = dir_n;
		rec.telemetry_request = tele_n;
		rec.frame_good        = good;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BITS; i++)
				hist_q[i] <= CODE_ERR;
			cnt_q  <= '0;
			sil_q  <= '0;
			last_q <= '0;
			rep_q  <= '0;
			dir_q  <= 1'b0;
			tele_q <= 1'b0;
			run_q  <= 1'b0;
			slow_q <= 1'b0;
			s1_v_q <= 1'b0;
		end else begin
			if (take_sample) begin
				for (int i = 0; i < FRAME_BITS - 1; i++)
					hist_q[i] <= hist_q[i+1];
				hist_q[FRAME_BITS-1] <= code;
			end
			if (accept) begin
				cnt_q  <= cnt_n;
				sil_q  <= sil_n;
				last_q <= last_n;
				rep_q  <= rep_n;
				dir_q  <= dir_n;
				tele_q <= tele_n;
				run_q  <= run_n;
				slow_q <= slow_n;
			end
			if (load)
				s1_v_q <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			s1_q <= rec;
	end

	assign dec_valid = s1_v_q;
	assign dec       = s1_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BUFFER_SIZE))
		else $error("sample count beyond buffer size");

	a_sil_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		is_tick |=> sil_q <= cfg.silence_limit)
		else $error("silence counter above limit after tick");

	a_rep_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= REPEAT_MAX)
		else $error("repeat count past saturation");

	a_save_cond: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_q.save_request) |-> (s1_q.frame_good && !s1_q.running))
		else $error("save request without good frame or while running");
`endif

endmodule

### rtl/dfr_speed_map.sv
module dfr_speed_map (
	input  logic              clk,
	input  logic              arst_n,
	input  dfr_pkg::cfg_t     cfg,
	input  logic              dec_valid,
	input  dfr_pkg::dec_t     dec,
	output logic              take,
	output logic              result_valid,
	input  logic              result_ready,
	output dfr_pkg::result_t  result
);
	import dfr_pkg::*;

	logic v2_q, v3_q, v4_q, v5_q, res_v_q;
	logic free2, free3, free4, free5, free_out;

	dec_t rec_s2, rec_s3, rec_s4, rec_s5, rec_out_q;

	logic [PROD_W-1:0]            prod_s2;
	logic [B_W-1:0]               b;
	logic [B_W-SPLIT+RECIP_W-1:0] pp_hi_s3;
	logic [SPLIT+RECIP_W-1:0]     pp_lo_s3;
	logic [7:0]                   blo_s3, blo_s4;
	logic [B_W+RECIP_W-1:0]       pp_sum;
	logic [QE_W-1:0]              qe_s4;
	logic [7:0]                   rem;
	logic [31:0]                  q_s5;
	logic [31:0]                  speed_q, speed_map, speed_n;

	// each stage loads when empty or when its content moves on
	assign free_out = !res_v_q || result_ready;
	assign free5    = !v5_q || free_out;
	assign free4    = !v4_q || free5;
	assign free3    = !v3_q || free4;
	assign free2    = !v2_q || free3;
	assign take     = free2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
			v4_q    <= 1'b0;
			v5_q    <= 1'b0;
			res_v_q <= 1'b0;
			speed_q <= '0;
		end else begin
			if (free2)
				v2_q <= dec_valid;
			if (free3)
				v3_q <= v2_q;
			if (free4)
				v4_q <= v3_q;
			if (free5)
				v5_q <= v4_q;
			if (free_out) begin
				res_v_q <= v5_q;
				if (v5_q)
					speed_q <= speed_n;
			end
		end
	end

	// x/2000 = floor((x>>4)/125); estimate is exact or one short
	assign b      = prod_s2[PROD_W-1:DIV_SHIFT];
	assign pp_sum = {pp_hi_s3, {SPLIT{1'b0}}} + (B_W+RECIP_W)'(pp_lo_s3);
	assign rem    = blo_s4 - qe_s4[7:0] * DIV_ODD;

	always_ff @(posedge clk) begin
		if (free2) begin
			rec_s2  <= dec;
			prod_s2 <= PROD_W'(cfg.span_abs) * PROD_W'(dec.thr_ofs);
		end
		if (free3) begin
			rec_s3   <= rec_s2;
			pp_hi_s3 <= b[B_W-1:SPLIT] * RECIP;
			pp_lo_s3 <= b[SPLIT-1:0] * RECIP;
			blo_s3   <= b[7:0];
		end
		if (free4) begin
			rec_s4 <= rec_s3;
			qe_s4  <= pp_sum[B_W+RECIP_W-1:RECIP_SHIFT];
			blo_s4 <= blo_s3;
		end
		if (free5) begin
			rec_s5 <= rec_s4;
			q_s5   <= qe_s4[31:0] + 32'(rem >= DIV_ODD);
		end
		if (free_out)
			rec_out_q <= rec_s5;
	end

	assign speed_map = cfg.span_neg ? cfg.speed_min - q_s5 : cfg.speed_min + q_s5;

	always_comb begin
		unique case (rec_s5.act)
			ACT_KEEP: speed_n = speed_q;
			ACT_ZERO: speed_n = '0;
			ACT_MAP:  speed_n = speed_map;
			default:  speed_n = speed_q;
		endcase
	end

	assign result_valid = res_v_q;

	always_comb begin
		result.running           = rec_out_q.running;
		result.slow_spin         = rec_out_q.slow_spin;
		result.speed_target      = speed_q;
		result.spin_direction    = rec_out_q.spin_direction;
		result.telemetry_request = rec_out_q.telemetry_request;
		result.frame_good        = rec_out_q.frame_good;
		result.save_request      = rec_out_q.save_request;
	end

endmodule

### rtl/dshot_frame_receiver.sv
// DShot frame receiver. Items are either pulse samples (kind 0) or ticks
// (kind 1). A sample is classified on entry against the zero and one width
// windows (zero window first) and shifted into a 16-bit history; it gives no
// result and is dropped once BUFFER_SIZE samples are held. Every tick gives
// exactly one result: it advances the silence watchdog and, when 16 or more
// samples are held, decodes the newest 16 as a frame (4-bit XOR CRC, nibble
// inverted in bidirectional mode), then applies throttle, repeat tracking and
// the stopped-motor commands 7, 8, 12, 15, 20 and 21. save_request is a
// one-result pulse. One item is accepted per cycle unless result_ready stalls
// the pipeline; a tick's result passes from the decode register through the
// throttle to speed scaling pipeline (span multiply, two reciprocal partial
// products, sum, remainder correction, output register). Configuration is
// written through cfg_we/cfg_index/cfg_data while no tick is in flight, which
// the user ensures, unchecked by the block; the span registers the speed limits.
module dshot_frame_receiver #(
	parameter int unsigned BUFFER_SIZE = dfr_pkg::BUFFER_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_ready,
	input  dfr_pkg::item_t                  item,
	// result channel
	output logic                            result_valid,
	input  logic                            result_ready,
	output dfr_pkg::result_t                result,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [dfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dfr_pkg::*;

	cfg_t cfg;
	dec_t dec;
	logic dec_valid;
	logic take;
	logic accept;

	// decode register is free when empty or draining into the scaler
	assign item_ready = !dec_valid || take;
	assign accept     = item_valid && item_ready;

	dfr_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sample history, watchdog, frame check and command handling
	dfr_decode #(
		.BUFFER_SIZE (BUFFER_SIZE)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.accept    (accept),
		.load      (item_ready),
		.cfg       (cfg),
		.dec_valid (dec_valid),
		.dec       (dec)
	);

	// throttle to speed scaling and the output register
	dfr_speed_map u_speed_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.dec_valid    (dec_valid),
		.dec          (dec),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
